// File: hw/rtl/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// tvsg_pkg: shared types and constants of the three-voice sound generator
// Item structs, operation codes and the bus register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvsg_pkg;

	// Operation codes carried in the opcode field
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SELECT = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Bus register map
	localparam logic [3:0] REG_TONE_A_LO  = 4'd0;
	localparam logic [3:0] REG_TONE_A_HI  = 4'd1;
	localparam logic [3:0] REG_TONE_B_LO  = 4'd2;
	localparam logic [3:0] REG_TONE_B_HI  = 4'd3;
	localparam logic [3:0] REG_TONE_C_LO  = 4'd4;
	localparam logic [3:0] REG_TONE_C_HI  = 4'd5;
	localparam logic [3:0] REG_NOISE_PER  = 4'd6;
	localparam logic [3:0] REG_MIXER      = 4'd7;
	localparam logic [3:0] REG_AMP_A      = 4'd8;
	localparam logic [3:0] REG_AMP_B      = 4'd9;
	localparam logic [3:0] REG_AMP_C      = 4'd10;
	localparam logic [3:0] REG_ENV_PER_LO = 4'd11;
	localparam logic [3:0] REG_ENV_PER_HI = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
	localparam logic [3:0] REG_PORT_A     = 4'd14;
	localparam logic [3:0] REG_PORT_B     = 4'd15;

	localparam int         NUM_VOICES = 3;
	localparam logic [4:0] ENV_TOP    = 5'd31;
	localparam logic [16:0] ENV_STEP  = 17'd2;
	localparam logic [16:0] LFSR_SEED = 17'd1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic [4:0] level_a;
		logic [4:0] level_b;
		logic [4:0] level_c;
		logic [7:0] read_data;
	} rsp_item_t;

endpackage

// File: hw/rtl/tvsg_engine.sv
// ----------------------------------------------------------------------------
// tvsg_engine: register file and tone, noise and envelope generators
// Updates state on each accepted item and forms its result in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvsg_engine
	import tvsg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  req_item_t req,
	output rsp_item_t rsp
);

	logic [11:0] tone_per_q   [NUM_VOICES];
	logic [3:0]  tone_spare_q [NUM_VOICES];
	logic [11:0] tone_cnt_q   [NUM_VOICES];
	logic        tone_lvl_q   [NUM_VOICES];
	logic [7:0]  amp_q        [NUM_VOICES];
	logic [7:0]  noise_per_q;
	logic [4:0]  noise_cnt_q;
	logic        noise_half_q;
	logic        noise_lvl_q;
	logic [16:0] lfsr_q;
	logic [7:0]  mixer_q;
	logic [15:0] env_per_q;
	logic [16:0] env_cnt_q;
	logic [7:0]  env_shape_q;
	logic        env_hold_q;
	logic        env_rise_q;
	logic [4:0]  env_lvl_q;
	logic [7:0]  port_a_q;
	logic [7:0]  port_b_q;
	logic [3:0]  sel_q;

	// Tick next state
	logic [11:0] tone_inc   [NUM_VOICES];
	logic        tone_fire  [NUM_VOICES];
	logic [11:0] tone_cnt_n [NUM_VOICES];
	logic        tone_lvl_n [NUM_VOICES];
	logic [4:0]  noise_inc;
	logic        noise_fire;
	logic [4:0]  noise_cnt_n;
	logic        noise_half_n;
	logic        noise_lvl_n;
	logic [16:0] lfsr_n;
	logic [16:0] env_inc;
	logic [16:0] env_cnt_n;
	logic        env_hold_n;
	logic        env_rise_n;
	logic [4:0]  env_lvl_n;
	logic [4:0]  voice_lvl  [NUM_VOICES];
	logic [7:0]  rd_data;

	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			tone_inc[i]   = tone_cnt_q[i] + 12'd1;
			tone_fire[i]  = (tone_inc[i] >= tone_per_q[i]);
			tone_cnt_n[i] = tone_fire[i] ? 12'd0 : tone_inc[i];
			tone_lvl_n[i] = tone_lvl_q[i] ^ tone_fire[i];
		end
	end

	assign noise_inc    = noise_cnt_q + 5'd1;
	assign noise_fire   = (noise_inc >= noise_per_q[4:0]);
	assign noise_cnt_n  = noise_fire ? 5'd0 : noise_inc;
	assign noise_half_n = noise_half_q ^ noise_fire;

	// Shift the LFSR on every second period event
	always_comb begin
		noise_lvl_n = noise_lvl_q;
		lfsr_n      = lfsr_q;
		if (noise_fire && !noise_half_q) begin
			noise_lvl_n = ~lfsr_q[0];
			lfsr_n      = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
		end
	end

	assign env_inc = env_cnt_q + ENV_STEP;

	always_comb begin
		env_cnt_n  = env_cnt_q;
		env_hold_n = env_hold_q;
		env_rise_n = env_rise_q;
		env_lvl_n  = env_lvl_q;
		if (!env_hold_q) begin
			if (env_inc < {1'b0, env_per_q}) begin
				env_cnt_n = env_inc;
			end else begin
				env_cnt_n = '0;
				if (!env_rise_q && env_lvl_q != 5'd0) begin
					env_lvl_n = env_lvl_q - 5'd1;
				end else if (env_rise_q && env_lvl_q != ENV_TOP) begin
					env_lvl_n = env_lvl_q + 5'd1;
				end else if (!env_shape_q[3]) begin
					// no repeat: drop to silence and stay there
					env_lvl_n  = 5'd0;
					env_hold_n = 1'b1;
				end else if (env_shape_q[0]) begin
					if (env_shape_q[1]) begin
						env_lvl_n = ~env_lvl_q;
					end
					env_hold_n = 1'b1;
				end else if (env_shape_q[1]) begin
					env_rise_n = ~env_rise_q;
				end else begin
					env_lvl_n = env_rise_q ? 5'd0 : ENV_TOP;
				end
			end
		end
	end

	// Mixer gating and level choice per voice
	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			if ((tone_lvl_n[i] | mixer_q[i]) & (noise_lvl_n | mixer_q[i + 3])) begin
				voice_lvl[i] = amp_q[i][4] ? env_lvl_n : {amp_q[i][3:0], 1'b1};
			end else begin
				voice_lvl[i] = 5'd0;
			end
		end
	end

	always_comb begin
		unique case (sel_q)
			REG_TONE_A_LO:  rd_data = tone_per_q[0][7:0];
			REG_TONE_A_HI:  rd_data = {tone_spare_q[0], tone_per_q[0][11:8]};
			REG_TONE_B_LO:  rd_data = tone_per_q[1][7:0];
			REG_TONE_B_HI:  rd_data = {tone_spare_q[1], tone_per_q[1][11:8]};
			REG_TONE_C_LO:  rd_data = tone_per_q[2][7:0];
			REG_TONE_C_HI:  rd_data = {tone_spare_q[2], tone_per_q[2][11:8]};
			REG_NOISE_PER:  rd_data = noise_per_q;
			REG_MIXER:      rd_data = mixer_q;
			REG_AMP_A:      rd_data = amp_q[0];
			REG_AMP_B:      rd_data = amp_q[1];
			REG_AMP_C:      rd_data = amp_q[2];
			REG_ENV_PER_LO: rd_data = env_per_q[7:0];
			REG_ENV_PER_HI: rd_data = env_per_q[15:8];
			REG_ENV_SHAPE:  rd_data = env_shape_q;
			REG_PORT_A:     rd_data = port_a_q;
			REG_PORT_B:     rd_data = port_b_q;
			default:        rd_data = port_b_q;
		endcase
	end

	always_comb begin
		rsp = '0;
		unique case (req.opcode)
			OP_TICK: begin
				rsp.level_a = voice_lvl[0];
				rsp.level_b = voice_lvl[1];
				rsp.level_c = voice_lvl[2];
			end
			OP_READ:   rsp.read_data = rd_data;
			OP_SELECT,
			OP_WRITE:  rsp = '0;
			default:   rsp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				tone_per_q[i]   <= '0;
				tone_spare_q[i] <= '0;
				tone_cnt_q[i]   <= '0;
				tone_lvl_q[i]   <= 1'b0;
				amp_q[i]        <= '0;
			end
			noise_per_q  <= '0;
			noise_cnt_q  <= '0;
			noise_half_q <= 1'b0;
			noise_lvl_q  <= 1'b0;
			lfsr_q       <= LFSR_SEED;
			mixer_q      <= '0;
			env_per_q    <= '0;
			env_cnt_q    <= '0;
			env_shape_q  <= '0;
			env_hold_q   <= 1'b0;
			env_rise_q   <= 1'b0;
			env_lvl_q    <= '0;
			port_a_q     <= '0;
			port_b_q     <= '0;
			sel_q        <= '0;
		end else if (en) begin
			unique case (req.opcode)
				OP_TICK: begin
					for (int i = 0; i < NUM_VOICES; i++) begin
						tone_cnt_q[i] <= tone_cnt_n[i];
						tone_lvl_q[i] <= tone_lvl_n[i];
					end
					noise_cnt_q  <= noise_cnt_n;
					noise_half_q <= noise_half_n;
					noise_lvl_q  <= noise_lvl_n;
					lfsr_q       <= lfsr_n;
					env_cnt_q    <= env_cnt_n;
					env_hold_q   <= env_hold_n;
					env_rise_q   <= env_rise_n;
					env_lvl_q    <= env_lvl_n;
				end
				OP_SELECT: sel_q <= req.data_byte[3:0];
				OP_WRITE: begin
					unique case (sel_q)
						REG_TONE_A_LO:  tone_per_q[0][7:0] <= req.data_byte;
						REG_TONE_A_HI: begin
							tone_per_q[0][11:8] <= req.data_byte[3:0];
							tone_spare_q[0]     <= req.data_byte[7:4];
						end
						REG_TONE_B_LO:  tone_per_q[1][7:0] <= req.data_byte;
						REG_TONE_B_HI: begin
							tone_per_q[1][11:8] <= req.data_byte[3:0];
							tone_spare_q[1]     <= req.data_byte[7:4];
						end
						REG_TONE_C_LO:  tone_per_q[2][7:0] <= req.data_byte;
						REG_TONE_C_HI: begin
							tone_per_q[2][11:8] <= req.data_byte[3:0];
							tone_spare_q[2]     <= req.data_byte[7:4];
						end
						REG_NOISE_PER:  noise_per_q <= req.data_byte;
						REG_MIXER:      mixer_q <= req.data_byte;
						REG_AMP_A:      amp_q[0] <= req.data_byte;
						REG_AMP_B:      amp_q[1] <= req.data_byte;
						REG_AMP_C:      amp_q[2] <= req.data_byte;
						REG_ENV_PER_LO: env_per_q[7:0] <= req.data_byte;
						REG_ENV_PER_HI: env_per_q[15:8] <= req.data_byte;
						REG_ENV_SHAPE: begin
							// restart the envelope; the counter keeps running
							env_shape_q <= req.data_byte;
							env_hold_q  <= 1'b0;
							env_rise_q  <= req.data_byte[2];
							env_lvl_q   <= req.data_byte[2] ? 5'd0 : ENV_TOP;
						end
						REG_PORT_A:     port_a_q <= req.data_byte;
						REG_PORT_B:     port_b_q <= req.data_byte;
						default:        port_b_q <= req.data_byte;
					endcase
				end
				OP_READ: sel_q <= sel_q;
				default: sel_q <= sel_q;
			endcase
		end
	end

`ifndef SYNTH
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 17'd0)
		else $error("noise LFSR reached the all-zero state");

	a_shape_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && req.opcode == OP_WRITE && sel_q == REG_ENV_SHAPE |=> !env_hold_q)
		else $error("envelope still holding after shape write");

	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && req.opcode != OP_TICK |=> $stable(tone_cnt_q[0]) && $stable(noise_cnt_q)
			&& $stable(env_cnt_q))
		else $error("generator counter moved on a bus item");
`endif

endmodule

// File: hw/rtl/three_voice_sound_generator_core.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_core: three-voice sound generator, bus and tick
// Results are registered in the output stage; a skid stage absorbs one item
// on output stall. Throughput: one item per cycle while the skid stage is empty.
// Reset: asynchronous, all generator state and registers cleared, LFSR set to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_voice_sound_generator_core
	import tvsg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_item
);

	logic      accept;
	logic      take;
	rsp_item_t result;
	rsp_item_t out_q;
	rsp_item_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;

	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;
	assign take      = out_valid_q && !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	tvsg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.req    (req_item),
		.rsp    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			// output held: park the item in the skid stage
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && out_valid_q && rsp_stall |=> skid_valid_q)
		else $error("item accepted under output stall was not parked");

	a_read_no_levels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.read_data != 8'd0 |->
			rsp_item.level_a == 5'd0 && rsp_item.level_b == 5'd0
			&& rsp_item.level_c == 5'd0)
		else $error("read result carries channel levels");
`endif

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-voice sound generator core
// Drives tick, select, write and read items through the valid/stall request
// port and predicts every output item with a behavioural copy of the tone,
// noise and envelope generators and the bus register file. Both ports idle at
// random; one long output hold-off fills the core and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import tvsg_pkg::*;

	localparam int ITEMS_TARGET     = 460;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int WATCHDOG_CYCLES  = 1000;
	localparam int SETTLE_CYCLES    = 8;

	// Envelope shape, amplitude and mixer bit positions
	localparam int SHAPE_HOLD     = 0;
	localparam int SHAPE_ALT      = 1;
	localparam int SHAPE_ATTACK   = 2;
	localparam int SHAPE_REPEAT   = 3;
	localparam int AMP_ENV_BIT    = 4;
	localparam int NOISE_DIS_BASE = 3;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp_item;

	three_voice_sound_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// Shadow of the chip state
	logic [11:0] tone_per [3];
	logic [3:0]  tone_spare [3];
	logic [11:0] tone_cnt [3];
	logic        tone_out [3];
	logic [7:0]  noise_per;
	logic [4:0]  noise_cnt;
	logic        noise_half;
	logic        noise_out;
	logic [16:0] lfsr;
	logic [7:0]  mixer;
	logic [7:0]  amp [3];
	logic [15:0] env_per;
	logic [16:0] env_cnt;
	logic [7:0]  env_shape;
	logic        env_frozen;
	logic        env_up;
	logic [4:0]  env_lvl;
	logic [7:0]  port_data [2];
	logic [3:0]  sel_reg;

	rsp_item_t pending_outputs [$];
	int        items_sent;
	int        mismatches;
	int        idle_cycles;
	bit        quiet;
	bit        hold_outputs;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Advance the shadow state by one item and return the output it gives
	function automatic rsp_item_t chip_response(input req_item_t it);
		rsp_item_t   res;
		logic [4:0]  lvl [3];
		logic [7:0]  v;
		int          i;

		res = '0;
		v = it.data_byte;
		case (it.opcode)
			OP_TICK: begin
				for (i = 0; i < NUM_VOICES; i++) begin
					tone_cnt[i] = tone_cnt[i] + 12'd1;
					if (tone_cnt[i] >= tone_per[i]) begin
						tone_cnt[i] = '0;
						tone_out[i] = !tone_out[i];
					end
				end
				noise_cnt = noise_cnt + 5'd1;
				if (noise_cnt >= noise_per[4:0]) begin
					noise_cnt = '0;
					noise_half = !noise_half;
					if (noise_half) begin
						noise_out = !lfsr[0];
						lfsr = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
					end
				end
				if (!env_frozen) begin
					env_cnt = env_cnt + ENV_STEP;
					if (env_cnt >= {1'b0, env_per}) begin
						env_cnt = '0;
						if (!env_up && env_lvl != 5'd0)
							env_lvl = env_lvl - 5'd1;
						else if (env_up && env_lvl != ENV_TOP)
							env_lvl = env_lvl + 5'd1;
						else if (!env_shape[SHAPE_REPEAT]) begin
							env_lvl = 5'd0;
							env_frozen = 1'b1;
						end else if (env_shape[SHAPE_HOLD]) begin
							if (env_shape[SHAPE_ALT])
								env_lvl = env_lvl ^ ENV_TOP;
							env_frozen = 1'b1;
						end else if (env_shape[SHAPE_ALT])
							env_up = !env_up;
						else
							env_lvl = env_up ? 5'd0 : ENV_TOP;
					end
				end
				for (i = 0; i < NUM_VOICES; i++) begin
					lvl[i] = 5'd0;
					if ((tone_out[i] | mixer[i]) & (noise_out | mixer[i + NOISE_DIS_BASE]))
						lvl[i] = amp[i][AMP_ENV_BIT] ? env_lvl : {amp[i][3:0], 1'b1};
				end
				res.level_a = lvl[0];
				res.level_b = lvl[1];
				res.level_c = lvl[2];
			end
			OP_SELECT: sel_reg = v[3:0];
			OP_WRITE: begin
				case (sel_reg)
					REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
						tone_per[sel_reg[2:1]][7:0] = v;
					REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
						tone_per[sel_reg[2:1]][11:8] = v[3:0];
						tone_spare[sel_reg[2:1]] = v[7:4];
					end
					REG_NOISE_PER: noise_per = v;
					REG_MIXER: mixer = v;
					REG_AMP_A, REG_AMP_B, REG_AMP_C: amp[sel_reg - REG_AMP_A] = v;
					REG_ENV_PER_LO: env_per[7:0] = v;
					REG_ENV_PER_HI: env_per[15:8] = v;
					REG_ENV_SHAPE: begin
						// restart the envelope, counter left alone
						env_shape = v;
						env_frozen = 1'b0;
						env_up = v[SHAPE_ATTACK];
						env_lvl = v[SHAPE_ATTACK] ? 5'd0 : ENV_TOP;
					end
					REG_PORT_A: port_data[0] = v;
					default: port_data[1] = v;
				endcase
			end
			default: begin
				case (sel_reg)
					REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
						res.read_data = tone_per[sel_reg[2:1]][7:0];
					REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
						res.read_data = {tone_spare[sel_reg[2:1]], tone_per[sel_reg[2:1]][11:8]};
					REG_NOISE_PER: res.read_data = noise_per;
					REG_MIXER: res.read_data = mixer;
					REG_AMP_A, REG_AMP_B, REG_AMP_C: res.read_data = amp[sel_reg - REG_AMP_A];
					REG_ENV_PER_LO: res.read_data = env_per[7:0];
					REG_ENV_PER_HI: res.read_data = env_per[15:8];
					REG_ENV_SHAPE: res.read_data = env_shape;
					REG_PORT_A: res.read_data = port_data[0];
					default: res.read_data = port_data[1];
				endcase
			end
		endcase
		return res;
	endfunction

	// Periods are kept short most of the time so that the generators turn over
	function automatic logic [7:0] pick_reg_value(input logic [3:0] r);
		case (r)
			REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_PER_LO:
				return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
			REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
				return {4'($urandom), ($urandom_range(0, 3) != 0) ? 4'd0 : 4'($urandom)};
			REG_ENV_PER_HI:
				return ($urandom_range(0, 5) != 0) ? 8'd0 : 8'($urandom);
			REG_NOISE_PER:
				return {3'($urandom), ($urandom_range(0, 3) != 0) ?
					5'($urandom_range(0, 3)) : 5'($urandom)};
			default:
				return 8'($urandom);
		endcase
	endfunction

	task automatic send_item(input req_item_t it);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (req_stall);
		pending_outputs.push_back(chip_response(it));
		items_sent++;
	endtask

	task automatic write_reg(input logic [3:0] r, input logic [7:0] v);
		send_item({OP_SELECT, 4'($urandom), r});
		send_item({OP_WRITE, v});
	endtask

	task automatic read_reg(input logic [3:0] r);
		send_item({OP_SELECT, 4'($urandom), r});
		send_item({OP_READ, 8'($urandom)});
	endtask

	task automatic tick_n(input int n);
		repeat (n) send_item({OP_TICK, 8'($urandom)});
	endtask

	task automatic test_directed_corners();
		tick_n(1);
		write_reg(REG_MIXER, 8'hFF);
		write_reg(REG_AMP_A, 8'h0F);
		write_reg(REG_AMP_B, 8'hE0);
		write_reg(REG_AMP_C, 8'h1F);
		write_reg(REG_ENV_SHAPE, 8'hFF);
		tick_n(2);
		read_reg(REG_ENV_SHAPE);
		write_reg(REG_TONE_A_HI, 8'hFF);
		read_reg(REG_TONE_A_HI);
		write_reg(REG_ENV_PER_HI, 8'hFF);
		send_item({OP_SELECT, 8'hFF});
		send_item({OP_READ, 8'h00});
		write_reg(REG_MIXER, 8'h00);
		tick_n(1);
	endtask

	task automatic test_register_readback();
		logic [3:0] r;
		for (int i = 0; i < 16; i++) begin
			r = 4'(i);
			write_reg(r, 8'($urandom));
			send_item({OP_READ, 8'($urandom)});
		end
	endtask

	// Fastest envelope so that each shape reaches its end; repeating shapes without hold turn over
	task automatic test_envelope_shapes();
		logic [3:0] s;
		write_reg(REG_ENV_PER_LO, 8'h00);
		write_reg(REG_ENV_PER_HI, 8'h00);
		write_reg(REG_MIXER, {2'($urandom), 6'h3F});
		write_reg(REG_AMP_A, {3'($urandom), 1'b1, 4'($urandom)});
		write_reg(REG_AMP_B, {3'($urandom), 1'b1, 4'($urandom)});
		for (int i = 0; i < 16; i++) begin
			s = 4'(i);
			if (s[SHAPE_REPEAT] || s[1:0] == 2'b00) begin
				write_reg(REG_ENV_SHAPE, {4'($urandom), s});
				tick_n(33 + $urandom_range(0, 1));
			end
		end
	endtask

	task automatic test_output_backpressure();
		quiet = 1'b1;
		hold_outputs = 1'b1;
		repeat (12) begin
			if ($urandom_range(0, 3) == 0)
				send_item({OP_READ, 8'($urandom)});
			else
				tick_n(1);
		end
		quiet = 1'b0;
	endtask

	task automatic test_random_traffic();
		logic [3:0] r;
		while (items_sent < ITEMS_TARGET) begin
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 5)) begin
				r = 4'($urandom);
				write_reg(r, pick_reg_value(r));
				if ($urandom_range(0, 2) == 0)
					send_item({OP_READ, 8'($urandom)});
			end
			repeat ($urandom_range(4, 48)) begin
				if ($urandom_range(0, 11) == 0)
					send_item({2'($urandom), 8'($urandom)});
				else
					tick_n(1);
			end
		end
		quiet = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : output_checker
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: output item %h with none expected", $time, rsp_item);
				mismatches++;
			end else begin
				want = pending_outputs.pop_front();
				check_field("level_a", 8'(want.level_a), 8'(rsp_item.level_a));
				check_field("level_b", 8'(want.level_b), 8'(rsp_item.level_b));
				check_field("level_c", 8'(want.level_c), 8'(rsp_item.level_c));
				check_field("read_data", want.read_data, rsp_item.read_data);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("three_voice_sound_generator_core: mismatch");
			$finish;
		end
	end

	// Output stall: random runs, or one long hold-off on request
	initial begin : rsp_stall_driver
		int run;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_outputs) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_outputs = 1'b0;
				rsp_stall <= 1'b0;
			end else begin
				run = quiet ? 0 : pick_gap();
				rsp_stall <= (run != 0);
				repeat (run) @(posedge clk);
				if (run != 0)
					rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		rsp_stall = 1'b0;
		items_sent = 0;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_outputs = 1'b0;
		for (int i = 0; i < NUM_VOICES; i++) begin
			tone_per[i] = '0;
			tone_spare[i] = '0;
			tone_cnt[i] = '0;
			tone_out[i] = 1'b0;
			amp[i] = '0;
		end
		noise_per = '0;
		noise_cnt = '0;
		noise_half = 1'b0;
		noise_out = 1'b0;
		lfsr = LFSR_SEED;
		mixer = '0;
		env_per = '0;
		env_cnt = '0;
		env_shape = '0;
		env_frozen = 1'b0;
		env_up = 1'b0;
		env_lvl = '0;
		port_data[0] = '0;
		port_data[1] = '0;
		sel_reg = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_register_readback();
		test_envelope_shapes();
		test_output_backpressure();
		test_random_traffic();
		req_valid <= 1'b0;

		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("three_voice_sound_generator_core: match");
		else
			$display("three_voice_sound_generator_core: mismatch");
		$finish;
	end

endmodule
